// ===== hw/rtl/cds_pkg.sv =====
// Shared types, register codes and fixed-point helpers for the 3D smoother.
package cds_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic [0:0] REG_SMOOTH_TIME = 1'd0;
  localparam logic [0:0] REG_MAX_SPEED   = 1'd1;

  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic signed [31:0] tgt_z;
    logic [30:0]        step_time;
  } cds_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               snapped;
  } cds_out_t;

  localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
  localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > SAT_MAX) return 32'sh7fffffff;
    if (v < SAT_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [67:0] s;
    s = 68'(a) + 68'(b);
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] sub32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [67:0] s;
    s = 68'(a) - 68'(b);
    return sat32(s);
  endfunction

  // Floor shift of a signed product, then saturate to 32 bits.
  function automatic logic signed [31:0] mulq(input logic signed [65:0] p,
                                              input int unsigned f);
    logic signed [65:0] s;
    s = p >>> f;
    return sat32(68'(s));
  endfunction

  // Shift of a non-negative product, saturated to 31 bits.
  function automatic logic [30:0] usatq(input logic signed [65:0] p,
                                        input int unsigned f);
    logic [65:0] s;
    s = 66'(p) >> f;
    if (s > 66'h7fffffff) return '1;
    return s[30:0];
  endfunction

endpackage

// ===== hw/rtl/cds_if.sv =====
// Valid/ready channel interfaces for the smoother's item and result streams.
interface cds_in_if;
  import cds_pkg::*;
  logic    valid;
  logic    ready;
  cds_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cds_out_if;
  import cds_pkg::*;
  logic     valid;
  logic     ready;
  cds_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/critically_damped_smoother_3d.sv =====
// Critically damped 3D smoother: shared multiplier, divider and root sequencer.
//
// Usage: din carries one transaction per step (current position, target
// position and step time); dout returns the smoothed position, the new
// velocity and the snapped flag. Both channels are valid/ready. The
// configuration port writes smooth_time (index 0) and max_speed (index 1)
// on any clock with cfg_we high; write only while the block is idle.
// Each item's run is set mostly by the shared radix-2 divider (spring rate,
// decay factor and three clamp quotients, the last only when the length
// clamp engages) and the 32-step square root; every product goes through
// one 33x33 multiplier with a registered result. din.ready is high only
// in the idle state.
// The result sits in an output register until taken; the next item is
// accepted as soon as the register is loaded, so a stalled receiver only
// holds the sequencer at its final step.
// Reset (rst, synchronous) clears the velocity, restores both registers
// to their defaults and empties the output register.
module critically_damped_smoother_3d #(
  parameter int unsigned FRAC_BITS = cds_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [30:0]     cfg_data,
  cds_in_if.sink          din,
  cds_out_if.source       dout
);
  import cds_pkg::*;

  localparam logic [63:0] ONE_Q   = 64'd1 << FRAC_BITS;
  localparam logic [30:0] MIN_ST  = 31'((64'd1 << FRAC_BITS) + 64'd9999) / 31'd10000;
  localparam logic [32:0] K48     = 33'((48 * (64'd1 << FRAC_BITS) + 50) / 100);
  localparam logic [32:0] K235    = 33'((235 * (64'd1 << FRAC_BITS) + 500) / 1000);
  localparam logic [63:0] OMG_NUM = 64'd2 << (2 * FRAC_BITS);
  localparam logic [63:0] EX_NUM  = 64'd1 << (2 * FRAC_BITS);
  localparam logic [30:0] ST_RST  = 31'd19661;
  localparam logic [6:0]  DIV_STEPS = 7'd64;

  localparam logic [5:0] S_IDLE = 6'd0,  S_OMG = 6'd1,  S_X0 = 6'd2,  S_X1 = 6'd3;
  localparam logic [5:0] S_X2 = 6'd4,    S_X3 = 6'd5,   S_X4 = 6'd6,  S_X5 = 6'd7;
  localparam logic [5:0] S_X6 = 6'd8,    S_X7 = 6'd9,   S_X8 = 6'd10, S_CHG = 6'd11;
  localparam logic [5:0] S_SQ0 = 6'd12,  S_SQ1 = 6'd13, S_MC0 = 6'd14, S_MC1 = 6'd15;
  localparam logic [5:0] S_MC2 = 6'd16,  S_MC3 = 6'd17, S_EXW = 6'd18, S_SQRT = 6'd19;
  localparam logic [5:0] S_CL0 = 6'd20,  S_CL1 = 6'd21, S_CL2 = 6'd22, S_P0 = 6'd23;
  localparam logic [5:0] S_P1 = 6'd24,   S_P2 = 6'd25,  S_P3 = 6'd26, S_P4 = 6'd27;
  localparam logic [5:0] S_P5 = 6'd28,   S_P6 = 6'd29,  S_P7 = 6'd30, S_D0 = 6'd31;
  localparam logic [5:0] S_D1 = 6'd32,   S_FIN = 6'd33, S_OUT = 6'd34;

  logic [5:0] state;
  logic [1:0] ci;

  logic [30:0] smooth_time, max_speed;
  logic signed [31:0] cur [3];
  logic signed [31:0] tgt [3];
  logic signed [31:0] chg [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] res [3];
  logic [30:0] dt, st, omega, x, x2, x3, mc;
  logic [33:0] d;
  logic [FRAC_BITS:0] ex;
  logic [63:0] sq;
  logic [31:0] len;
  logic signed [31:0] goal, acc, acc2, tmp;
  logic signed [67:0] dot;
  logic snap;

  // shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;

  // shared divider
  logic [63:0] dv_q, dv_d;
  logic [64:0] dv_r, dv_rs;
  logic [6:0]  dv_cnt;
  logic        dv_ge;
  logic        div_start;
  logic [63:0] div_num, div_den;

  // square root
  logic [63:0] sv, sr, sb, s_sum;

  logic         ovalid;
  cds_out_t     odata;

  logic signed [32:0] abs_chg;
  logic signed [31:0] dif_a, dif_b;

  assign din.ready  = (state == S_IDLE);
  assign dout.valid = ovalid;
  assign dout.data  = odata;

  assign abs_chg = chg[ci][31] ? -{chg[ci][31], chg[ci]} : {1'b0, chg[ci]};
  assign dif_a   = sub32(tgt[ci], cur[ci]);
  assign dif_b   = sub32(res[ci], tgt[ci]);
  assign dv_rs   = {dv_r[63:0], dv_q[63]};
  assign dv_ge   = dv_rs >= {1'b0, dv_d};
  assign s_sum   = sr + sb;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_X0:  begin ma = {2'b0, omega};    mb = {2'b0, dt};    end
      S_X2:  begin ma = {2'b0, x};        mb = {2'b0, x};     end
      S_X4:  begin ma = {2'b0, x2};       mb = {2'b0, x};     end
      S_X5:  begin ma = {2'b0, x2};       mb = K48;           end
      S_X6:  begin ma = {2'b0, x3};       mb = K235;          end
      S_SQ0: begin ma = {chg[ci][31], chg[ci]}; mb = {chg[ci][31], chg[ci]}; end
      S_MC0: begin ma = {2'b0, max_speed}; mb = {2'b0, st};   end
      S_MC2: begin ma = {2'b0, mc};       mb = {2'b0, mc};    end
      S_CL0: begin ma = abs_chg;          mb = {2'b0, mc};    end
      S_P0:  begin ma = {chg[ci][31], chg[ci]}; mb = {2'b0, omega}; end
      S_P2:  begin ma = {acc[31], acc};   mb = {2'b0, dt};    end
      S_P4:  begin ma = {tmp[31], tmp};   mb = {2'b0, omega}; end
      S_P5:  begin ma = {acc[31], acc};   mb = 33'(ex);       end
      S_P6:  begin ma = {acc2[31], acc2}; mb = 33'(ex);       end
      S_D0:  begin ma = {dif_a[31], dif_a}; mb = {dif_b[31], dif_b}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      S_IDLE: begin
        div_start = din.valid;
        div_num   = OMG_NUM;
        div_den   = {33'b0, (smooth_time < MIN_ST) ? MIN_ST : smooth_time};
      end
      S_X8: begin
        div_start = 1'b1;
        div_num   = EX_NUM;
        div_den   = {30'b0, d};
      end
      S_CL1: begin
        div_start = 1'b1;
        div_num   = prod[63:0];
        div_den   = {32'b0, len};
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // divider and square root iterate on their own once started
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
      sb     <= '0;
    end else begin
      if (div_start) begin
        dv_q   <= div_num;
        dv_d   <= div_den;
        dv_r   <= '0;
        dv_cnt <= DIV_STEPS;
      end else if (dv_cnt != 7'd0) begin
        dv_r   <= dv_ge ? dv_rs - {1'b0, dv_d} : dv_rs;
        dv_q   <= {dv_q[62:0], dv_ge};
        dv_cnt <= dv_cnt - 7'd1;
      end
      if (state == S_MC3) begin
        sv <= sq;
        sr <= '0;
        sb <= 64'd1 << 62;
      end else if (sb != 64'd0) begin
        if (sv >= s_sum) begin
          sv <= sv - s_sum;
          sr <= (sr >> 1) + sb;
        end else begin
          sr <= sr >> 1;
        end
        sb <= sb >> 2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ci          <= '0;
      smooth_time <= ST_RST;
      max_speed   <= '1;
      ovalid      <= 1'b0;
      for (int i = 0; i < 3; i++) vel[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SMOOTH_TIME: smooth_time <= cfg_data;
          REG_MAX_SPEED:   max_speed   <= cfg_data;
          default: ;
        endcase
      end
      if (ovalid && dout.ready && (state != S_OUT)) ovalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (din.valid) begin
            cur[0] <= din.data.cur_x;
            cur[1] <= din.data.cur_y;
            cur[2] <= din.data.cur_z;
            tgt[0] <= din.data.tgt_x;
            tgt[1] <= din.data.tgt_y;
            tgt[2] <= din.data.tgt_z;
            dt     <= din.data.step_time;
            st     <= (smooth_time < MIN_ST) ? MIN_ST : smooth_time;
            sq     <= '0;
            state  <= S_OMG;
          end
        end
        S_OMG: begin
          if (dv_cnt == 7'd0) begin
            omega <= (dv_q > 64'h7fffffff) ? '1 : dv_q[30:0];
            state <= S_X0;
          end
        end
        S_X0: state <= S_X1;
        S_X1: begin x <= usatq(prod, FRAC_BITS); state <= S_X2; end
        S_X2: state <= S_X3;
        S_X3: begin x2 <= usatq(prod, FRAC_BITS); state <= S_X4; end
        S_X4: state <= S_X5;
        S_X5: begin x3 <= usatq(prod, FRAC_BITS); state <= S_X6; end
        S_X6: begin
          d     <= ONE_Q[33:0] + {3'b0, x} + 34'(66'(prod) >> FRAC_BITS);
          state <= S_X7;
        end
        S_X7: begin
          d     <= d + 34'(66'(prod) >> FRAC_BITS);
          state <= S_X8;
        end
        S_X8: begin ci <= '0; state <= S_CHG; end
        S_CHG: begin chg[ci] <= sub32(cur[ci], tgt[ci]); state <= S_SQ0; end
        S_SQ0: state <= S_SQ1;
        S_SQ1: begin
          sq <= sq + prod[63:0];
          if (ci == 2'd2) begin
            ci    <= '0;
            state <= S_MC0;
          end else begin
            ci    <= ci + 2'd1;
            state <= S_CHG;
          end
        end
        S_MC0: state <= S_MC1;
        S_MC1: begin mc <= usatq(prod, FRAC_BITS); state <= S_MC2; end
        S_MC2: state <= S_MC3;
        S_MC3: state <= (sq > prod[63:0]) ? S_SQRT : S_EXW;
        S_EXW: begin
          if (dv_cnt == 7'd0) begin
            ex    <= dv_q[FRAC_BITS:0];
            ci    <= '0;
            state <= S_P0;
          end
        end
        S_SQRT: begin
          if (dv_cnt == 7'd0 && sb == 64'd0) begin
            ex    <= dv_q[FRAC_BITS:0];
            len   <= (sr[31:0] == 32'd0) ? 32'd1 : sr[31:0];
            ci    <= '0;
            state <= S_CL0;
          end
        end
        S_CL0: state <= S_CL1;
        S_CL1: state <= S_CL2;
        S_CL2: begin
          if (dv_cnt == 7'd0) begin
            chg[ci] <= chg[ci][31] ? -dv_q[31:0] : dv_q[31:0];
            if (ci == 2'd2) begin
              ci    <= '0;
              state <= S_P0;
            end else begin
              ci    <= ci + 2'd1;
              state <= S_CL0;
            end
          end
        end
        S_P0: begin goal <= sub32(cur[ci], chg[ci]); state <= S_P1; end
        S_P1: begin acc <= add32(vel[ci], mulq(prod, FRAC_BITS)); state <= S_P2; end
        S_P2: state <= S_P3;
        S_P3: begin tmp <= mulq(prod, FRAC_BITS); state <= S_P4; end
        S_P4: begin acc <= add32(chg[ci], tmp); state <= S_P5; end
        S_P5: begin acc2 <= sub32(vel[ci], mulq(prod, FRAC_BITS)); state <= S_P6; end
        S_P6: begin res[ci] <= add32(goal, mulq(prod, FRAC_BITS)); state <= S_P7; end
        S_P7: begin
          vel[ci] <= mulq(prod, FRAC_BITS);
          if (ci == 2'd2) begin
            ci    <= '0;
            dot   <= '0;
            state <= S_D0;
          end else begin
            ci    <= ci + 2'd1;
            state <= S_P0;
          end
        end
        S_D0: state <= S_D1;
        S_D1: begin
          dot <= dot + 68'(prod);
          if (ci == 2'd2) begin
            state <= S_FIN;
          end else begin
            ci    <= ci + 2'd1;
            state <= S_D0;
          end
        end
        S_FIN: begin
          snap <= !dot[67] && (dot != '0);
          if (!dot[67] && (dot != '0)) begin
            for (int i = 0; i < 3; i++) vel[i] <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!ovalid || dout.ready) begin
            odata.out_x   <= snap ? tgt[0] : res[0];
            odata.out_y   <= snap ? tgt[1] : res[1];
            odata.out_z   <= snap ? tgt[2] : res[2];
            odata.vel_x   <= vel[0];
            odata.vel_y   <= vel[1];
            odata.vel_z   <= vel[2];
            odata.snapped <= snap;
            ovalid        <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
